// ===== src/mert_pkg.sv =====
package mert_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int SUM_W      = 48;
	localparam int OUT_W      = 32;
	localparam int DIFF_W     = SAMPLE_W + 1;
	localparam int SQ_W       = 2 * DIFF_W;
	localparam int QUOT_W     = 2 * OUT_W;
	localparam int DIV_STEPS  = SUM_W + OUT_W;
	localparam int ROOT_STEPS = OUT_W;
	localparam int STEP_CNT_W = $clog2(DIV_STEPS);
	localparam int RREM_W     = OUT_W + 2;
	localparam int QUEUE_DEPTH = 2;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_USE_MASK       = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TIME_SCALE_MIN = CFG_IDX_W'(1);

	localparam logic [OUT_W-1:0] TIME_SCALE_MIN_RST = OUT_W'(65536);
	localparam logic [OUT_W-1:0] OUT_MAX            = '1;
	localparam logic [SUM_W-1:0] SUM_MAX            = '1;

	typedef struct packed {
		logic [SUM_W-1:0] input_sum;
		logic [SUM_W-1:0] error_sum;
	} sums_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic one_left;
	} q_status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_ROOT
	} bk_state_t;

endpackage

// ===== src/masked_error_ratio_timescale_top.sv =====
// Masked error-ratio time scale. Issue one neuron per transaction with start
// while busy is low; the front end squares and accumulates at one transaction
// per clock while busy stays low. A transaction with last closes the layer:
// its sums go into a small queue and the back end computes sqrt(input/error)
// as Q16.16 with a one-bit-per-cycle divider followed by a two-bits-per-cycle
// root. A layer whose error sum is zero or whose ratio saturates skips the
// divider and the root. done strobes each result for one cycle and cannot be
// held off. The back end computes one layer at a time and pops another only
// when it is back in idle. busy rises only while the queue of finished layers
// is full or about to be filled, which takes a run of layers that close faster
// than the back end computes them; otherwise the block accepts a neuron every
// cycle.
module masked_error_ratio_timescale_top #(
	parameter int QUEUE_DEPTH = mert_pkg::QUEUE_DEPTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [mert_pkg::SAMPLE_W-1:0]   exc_sample,
	input  logic signed [mert_pkg::SAMPLE_W-1:0]   inh_sample,
	input  logic                                  mask_on,
	input  logic                                  last,
	input  logic                                  cfg_we,
	input  logic [mert_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [mert_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	output logic                                  done,
	output logic [mert_pkg::OUT_W-1:0]             time_scale,
	output logic                                  used_minimum
);

	logic                       use_mask_q;
	logic [mert_pkg::OUT_W-1:0] time_scale_min_q;
	logic                       push;
	logic                       pop;
	mert_pkg::sums_t            push_data;
	mert_pkg::sums_t            pop_data;
	mert_pkg::q_status_t        q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_mask_q       <= 1'b0;
			time_scale_min_q <= mert_pkg::TIME_SCALE_MIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mert_pkg::REG_USE_MASK:       use_mask_q <= cfg_wdata[0];
				mert_pkg::REG_TIME_SCALE_MIN: time_scale_min_q <= cfg_wdata[mert_pkg::OUT_W-1:0];
				default:                      use_mask_q <= use_mask_q;
			endcase
		end
	end

	mert_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.exc_sample (exc_sample),
		.inh_sample (inh_sample),
		.mask_on    (mask_on),
		.last       (last),
		.use_mask   (use_mask_q),
		.q_stat     (q_stat),
		.busy       (busy),
		.push       (push),
		.push_data  (push_data)
	);

	mert_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	mert_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.pop_data       (pop_data),
		.q_stat         (q_stat),
		.time_scale_min (time_scale_min_q),
		.pop            (pop),
		.done           (done),
		.time_scale     (time_scale),
		.used_minimum   (used_minimum)
	);

endmodule

// ===== src/mert_front.sv =====
module mert_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [mert_pkg::SAMPLE_W-1:0] exc_sample,
	input  logic signed [mert_pkg::SAMPLE_W-1:0] inh_sample,
	input  logic                                mask_on,
	input  logic                                last,
	input  logic                                use_mask,
	input  mert_pkg::q_status_t                 q_stat,
	output logic                                busy,
	output logic                                push,
	output mert_pkg::sums_t                     push_data
);

	logic                              accept;
	logic                              take;
	logic signed [mert_pkg::DIFF_W-1:0] exc_x;
	logic signed [mert_pkg::DIFF_W-1:0] inh_x;
	logic signed [mert_pkg::DIFF_W-1:0] diff;
	logic [mert_pkg::DIFF_W-1:0]        diff_abs;
	logic [mert_pkg::DIFF_W-1:0]        exc_abs;
	logic [mert_pkg::SQ_W-1:0]          err_sq;
	logic [mert_pkg::SQ_W-1:0]          in_sq;

	logic                              vld_s1;
	logic                              last_s1;
	logic [mert_pkg::SQ_W-1:0]          err_sq_s1;
	logic [mert_pkg::SQ_W-1:0]          in_sq_s1;

	logic [mert_pkg::SUM_W-1:0]         error_sum_q;
	logic [mert_pkg::SUM_W-1:0]         input_sum_q;
	logic [mert_pkg::SUM_W:0]           err_add;
	logic [mert_pkg::SUM_W:0]           in_add;
	logic [mert_pkg::SUM_W-1:0]         err_new;
	logic [mert_pkg::SUM_W-1:0]         in_new;

	assign busy   = q_stat.full || (q_stat.one_left && vld_s1 && last_s1);
	assign accept = start && !busy;
	assign take   = !(use_mask && !mask_on);

	assign exc_x    = {exc_sample[mert_pkg::SAMPLE_W-1], exc_sample};
	assign inh_x    = {inh_sample[mert_pkg::SAMPLE_W-1], inh_sample};
	assign diff     = exc_x - inh_x;
	assign diff_abs = diff[mert_pkg::DIFF_W-1] ? -diff : diff;
	assign exc_abs  = exc_x[mert_pkg::DIFF_W-1] ? -exc_x : exc_x;
	assign err_sq   = diff_abs * diff_abs;
	assign in_sq    = exc_abs * exc_abs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			vld_s1  <= accept;
			last_s1 <= accept && last;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			err_sq_s1 <= take ? err_sq : '0;
			in_sq_s1  <= take ? in_sq : '0;
		end
	end

	assign err_add = {1'b0, error_sum_q} + (mert_pkg::SUM_W + 1)'(err_sq_s1);
	assign in_add  = {1'b0, input_sum_q} + (mert_pkg::SUM_W + 1)'(in_sq_s1);
	assign err_new = err_add[mert_pkg::SUM_W] ? mert_pkg::SUM_MAX
		: err_add[mert_pkg::SUM_W-1:0];
	assign in_new  = in_add[mert_pkg::SUM_W] ? mert_pkg::SUM_MAX
		: in_add[mert_pkg::SUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q <= '0;
			input_sum_q <= '0;
		end else if (vld_s1) begin
			if (last_s1) begin
				error_sum_q <= '0;
				input_sum_q <= '0;
			end else begin
				error_sum_q <= err_new;
				input_sum_q <= in_new;
			end
		end
	end

	assign push                = vld_s1 && last_s1;
	assign push_data.input_sum = in_new;
	assign push_data.error_sum = err_new;

endmodule

// ===== src/mert_queue.sv =====
module mert_queue #(
	parameter int DEPTH = mert_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mert_pkg::sums_t     push_data,
	input  logic                pop,
	output mert_pkg::sums_t     pop_data,
	output mert_pkg::q_status_t q_stat
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	mert_pkg::sums_t    mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_pop;

	assign do_pop = pop && (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign pop_data        = mem_q[rd_ptr_q];
	assign q_stat.empty    = (count_q == '0);
	assign q_stat.full     = (count_q == CNT_W'(DEPTH));
	assign q_stat.one_left = (count_q == CNT_W'(DEPTH - 1));

endmodule

// ===== src/mert_back.sv =====
module mert_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mert_pkg::sums_t           pop_data,
	input  mert_pkg::q_status_t       q_stat,
	input  logic [mert_pkg::OUT_W-1:0] time_scale_min,
	output logic                      pop,
	output logic                      done,
	output logic [mert_pkg::OUT_W-1:0] time_scale,
	output logic                      used_minimum
);

	localparam int HEAD_W = mert_pkg::SUM_W - mert_pkg::OUT_W;

	mert_pkg::bk_state_t state_q, state_nx;

	logic [mert_pkg::SUM_W-1:0]      num_q;
	logic [mert_pkg::SUM_W-1:0]      den_q;
	logic [mert_pkg::SUM_W-1:0]      rem_q;
	logic [mert_pkg::QUOT_W-1:0]     q_q;
	logic [mert_pkg::RREM_W-1:0]     rrem_q;
	logic [mert_pkg::OUT_W-1:0]      root_q;
	logic [mert_pkg::STEP_CNT_W-1:0] cnt_q;
	logic                            done_q;
	logic [mert_pkg::OUT_W-1:0]      time_scale_q;
	logic                            used_min_q;

	logic                            zero_den;
	logic                            ovf;
	logic                            last_div;
	logic                            last_root;

	logic                            emit_min;
	logic                            emit_max;
	logic                            load;
	logic                            div_step;
	logic                            root_step;
	logic                            emit_root;

	logic [mert_pkg::SUM_W:0]        trial;
	logic                            ge;
	logic [mert_pkg::SUM_W:0]        rem_nx;
	logic [mert_pkg::QUOT_W-1:0]     q_nx;
	logic [mert_pkg::RREM_W+1:0]     rsh;
	logic [mert_pkg::RREM_W+1:0]     rtrial;
	logic                            rge;
	logic [mert_pkg::RREM_W+1:0]     rrem_nx;
	logic [mert_pkg::OUT_W-1:0]      root_nx;

	assign zero_den  = (pop_data.error_sum == '0);
	// quotient would reach 2^64: input >= error * 2^32
	assign ovf       = (pop_data.error_sum[mert_pkg::SUM_W-1 -: mert_pkg::OUT_W] == '0)
		&& (pop_data.input_sum >= {pop_data.error_sum[HEAD_W-1:0],
			{mert_pkg::OUT_W{1'b0}}});
	assign last_div  = (cnt_q == mert_pkg::STEP_CNT_W'(mert_pkg::DIV_STEPS - 1));
	assign last_root = (cnt_q == mert_pkg::STEP_CNT_W'(mert_pkg::ROOT_STEPS - 1));

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			mert_pkg::BK_IDLE: begin
				if (!q_stat.empty && !zero_den && !ovf) begin
					state_nx = mert_pkg::BK_DIV;
				end
			end
			mert_pkg::BK_DIV: begin
				if (last_div) begin
					state_nx = mert_pkg::BK_ROOT;
				end
			end
			mert_pkg::BK_ROOT: begin
				if (last_root) begin
					state_nx = mert_pkg::BK_IDLE;
				end
			end
			default: state_nx = mert_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		emit_min  = 1'b0;
		emit_max  = 1'b0;
		load      = 1'b0;
		div_step  = 1'b0;
		root_step = 1'b0;
		emit_root = 1'b0;
		unique case (state_q)
			mert_pkg::BK_IDLE: begin
				if (!q_stat.empty) begin
					pop = 1'b1;
					priority if (zero_den) begin
						emit_min = 1'b1;
					end else if (ovf) begin
						emit_max = 1'b1;
					end else begin
						load = 1'b1;
					end
				end
			end
			mert_pkg::BK_DIV: begin
				div_step = 1'b1;
			end
			mert_pkg::BK_ROOT: begin
				root_step = 1'b1;
				emit_root = last_root;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// restoring divide: input_sum * 2^32 / error_sum, one quotient bit per cycle
	assign trial  = {rem_q, num_q[mert_pkg::SUM_W-1]};
	assign ge     = (trial >= {1'b0, den_q});
	assign rem_nx = ge ? trial - {1'b0, den_q} : trial;
	assign q_nx   = {q_q[mert_pkg::QUOT_W-2:0], ge};

	// digit-by-digit square root, two radicand bits per cycle
	assign rsh     = {rrem_q, q_q[mert_pkg::QUOT_W-1 -: 2]};
	assign rtrial  = (mert_pkg::RREM_W + 2)'({root_q, 2'b01});
	assign rge     = (rsh >= rtrial);
	assign rrem_nx = rge ? rsh - rtrial : rsh;
	assign root_nx = {root_q[mert_pkg::OUT_W-2:0], rge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mert_pkg::BK_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (load || (div_step && last_div) || (root_step && last_root)) begin
				cnt_q <= '0;
			end else if (div_step || root_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			num_q <= pop_data.input_sum;
			den_q <= pop_data.error_sum;
			rem_q <= '0;
			q_q   <= '0;
		end else if (div_step) begin
			num_q  <= {num_q[mert_pkg::SUM_W-2:0], 1'b0};
			rem_q  <= rem_nx[mert_pkg::SUM_W-1:0];
			q_q    <= q_nx;
			rrem_q <= '0;
			root_q <= '0;
		end else if (root_step) begin
			q_q    <= {q_q[mert_pkg::QUOT_W-3:0], 2'b00};
			rrem_q <= rrem_nx[mert_pkg::RREM_W-1:0];
			root_q <= root_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q       <= 1'b0;
			time_scale_q <= '0;
			used_min_q   <= 1'b0;
		end else begin
			done_q     <= emit_min || emit_max || emit_root;
			used_min_q <= emit_min;
			priority if (emit_min) begin
				time_scale_q <= time_scale_min;
			end else if (emit_max) begin
				time_scale_q <= mert_pkg::OUT_MAX;
			end else if (emit_root) begin
				time_scale_q <= root_nx;
			end else begin
				time_scale_q <= '0;
			end
		end
	end

	assign done         = done_q;
	assign time_scale   = time_scale_q;
	assign used_minimum = used_min_q;

endmodule

// ===== src/mert_checker.sv =====
module mert_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      last,
	input logic                      done,
	input logic [mert_pkg::OUT_W-1:0] time_scale,
	input logic                      used_minimum
);

	// result ports are quiet between strobes
	a_flag_only_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> !used_minimum)
		else $error("used_minimum high without done");

	a_value_only_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> (time_scale == '0))
		else $error("time_scale nonzero without done");

	// back pressure only follows a layer-closing transaction
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && last))
		else $error("busy rose without a preceding last transaction");

endmodule

bind masked_error_ratio_timescale_top mert_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.last         (last),
	.done         (done),
	.time_scale   (time_scale),
	.used_minimum (used_minimum)
);

// ===== test/masked_error_ratio_timescale_top_test.sv =====
`timescale 1ns / 1ps

module masked_error_ratio_timescale_top_test;

	localparam int SETTLE_CYCLES = 130;
	localparam int W = mert_pkg::SAMPLE_W;

	typedef struct {
		logic [mert_pkg::OUT_W-1:0] time_scale;
		logic                       used_minimum;
	} layer_result_t;

	logic                              clk;
	logic                              arst_n = 1'b0;
	logic                              start = 1'b0;
	logic                              busy;
	logic signed [W-1:0]               exc_sample = '0;
	logic signed [W-1:0]               inh_sample = '0;
	logic                              mask_on = 1'b0;
	logic                              last = 1'b0;
	logic                              cfg_we = 1'b0;
	logic [mert_pkg::CFG_IDX_W-1:0]    cfg_index = mert_pkg::REG_USE_MASK;
	logic [mert_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;
	logic                              done;
	logic [mert_pkg::OUT_W-1:0]        time_scale;
	logic                              used_minimum;

	// predictor state
	logic                              mask_enable = 1'b0;
	logic [mert_pkg::OUT_W-1:0]        min_scale = mert_pkg::TIME_SCALE_MIN_RST;
	logic [mert_pkg::SUM_W-1:0]        err_acc = '0;
	logic [mert_pkg::SUM_W-1:0]        in_acc = '0;

	layer_result_t expected_scales[$];
	int failures = 0;
	int neurons_in = 0;
	int layers_checked = 0;
	int minimum_layers = 0;
	int saturated_layers = 0;
	int gap_pct = 0;

	masked_error_ratio_timescale_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.exc_sample(exc_sample),
		.inh_sample(inh_sample),
		.mask_on(mask_on),
		.last(last),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.time_scale(time_scale),
		.used_minimum(used_minimum)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic logic [mert_pkg::SUM_W-1:0] sat_accumulate(
		logic [mert_pkg::SUM_W-1:0] acc, logic [W:0] mag);
		logic [63:0] sq;
		logic [mert_pkg::SUM_W:0] total;
		sq = 64'(mag) * 64'(mag);
		total = (mert_pkg::SUM_W+1)'(acc) + (mert_pkg::SUM_W+1)'(sq);
		return total[mert_pkg::SUM_W] ? mert_pkg::SUM_MAX : total[mert_pkg::SUM_W-1:0];
	endfunction

	function automatic void absorb_neuron(logic [W-1:0] e, logic [W-1:0] i, logic m);
		logic [W:0] diff;
		logic [W:0] ext_e;
		if (mask_enable && !m)
			return;
		ext_e = {e[W-1], e};
		diff = ext_e - {i[W-1], i};
		err_acc = sat_accumulate(err_acc, diff[W] ? -diff : diff);
		in_acc = sat_accumulate(in_acc, ext_e[W] ? -ext_e : ext_e);
	endfunction

	function automatic logic [31:0] floor_root(logic [63:0] v);
		logic [31:0] root;
		logic [31:0] trial;
		root = '0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (32'd1 << b);
			if (64'(trial) * 64'(trial) <= v)
				root = trial;
		end
		return root;
	endfunction

	function automatic layer_result_t close_layer();
		layer_result_t r;
		logic [79:0] quot;
		if (err_acc == '0) begin
			r.time_scale = min_scale;
			r.used_minimum = 1'b1;
		end else begin
			quot = {in_acc, 32'h0} / 80'(err_acc);
			r.time_scale = (quot[79:64] != '0) ? mert_pkg::OUT_MAX : floor_root(quot[63:0]);
			r.used_minimum = 1'b0;
		end
		err_acc = '0;
		in_acc = '0;
		return r;
	endfunction

	always @(posedge clk) begin
		layer_result_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_scales.size() == 0) begin
					$error("unexpected result: time_scale %h used_minimum %b",
						time_scale, used_minimum);
					failures++;
				end else begin
					want = expected_scales.pop_front();
					layers_checked++;
					if (want.used_minimum)
						minimum_layers++;
					else if (want.time_scale == mert_pkg::OUT_MAX)
						saturated_layers++;
					if (time_scale !== want.time_scale) begin
						$error("time_scale: expected %h, got %h", want.time_scale, time_scale);
						failures++;
					end
					if (used_minimum !== want.used_minimum) begin
						$error("used_minimum: expected %b, got %b",
							want.used_minimum, used_minimum);
						failures++;
					end
				end
			end
			if (start && !busy) begin
				neurons_in++;
				absorb_neuron(exc_sample, inh_sample, mask_on);
				if (last)
					expected_scales.push_back(close_layer());
			end
			if (cfg_we) begin
				if (cfg_index == mert_pkg::REG_USE_MASK)
					mask_enable = cfg_wdata[0];
				else if (cfg_index == mert_pkg::REG_TIME_SCALE_MIN)
					min_scale = cfg_wdata;
			end
		end
	end

	task automatic send_neuron(input logic [W-1:0] e, input logic [W-1:0] i,
		input logic m, input logic l);
		start <= 1'b1;
		exc_sample <= e;
		inh_sample <= i;
		mask_on <= m;
		last <= l;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			exc_sample <= W'($urandom);
			inh_sample <= W'($urandom);
			mask_on <= 1'($urandom);
			last <= 1'($urandom);
			repeat ($urandom_range(1, 10))
				@(posedge clk);
		end
	endtask

	task automatic settle();
		start <= 1'b0;
		while (expected_scales.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [mert_pkg::CFG_IDX_W-1:0] idx,
		input logic [mert_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// upper bits of the write data are junk, only bit 0 matters
	task automatic write_mask_enable(input logic en);
		logic [31:0] data;
		data = $urandom;
		data[0] = en;
		write_reg(mert_pkg::REG_USE_MASK, data);
	endtask

	task automatic draw_samples(input int style, output logic [W-1:0] e,
		output logic [W-1:0] i);
		e = W'($urandom);
		i = W'($urandom);
		case (style)
			1: begin
				e = W'($urandom_range(0, 511)) - W'(256);
				i = W'($urandom_range(0, 511)) - W'(256);
			end
			2: i = e;
			3: begin
				case ($urandom_range(0, 4))
					0: e = 16'h8000;
					1: e = 16'h7FFF;
					2: e = 16'h0000;
					3: e = 16'hFFFF;
					default: e = 16'h0001;
				endcase
				case ($urandom_range(0, 4))
					0: i = 16'h8000;
					1: i = 16'h7FFF;
					2: i = 16'h0000;
					3: i = 16'hFFFF;
					default: i = 16'h0001;
				endcase
			end
			4: i = e + W'($urandom_range(0, 6)) - W'(3);
			5: i = W'($urandom_range(0, 15)) - W'(8) + e;
			default: ;
		endcase
	endtask

	task automatic random_layers(input int count);
		int sent;
		int len;
		int style;
		logic [W-1:0] e;
		logic [W-1:0] i;
		sent = 0;
		while (sent < count) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: len = $urandom_range(1, 6);
				6, 7, 8: len = $urandom_range(7, 40);
				default: len = $urandom_range(41, 150);
			endcase
			style = $urandom_range(0, 5);
			for (int k = 0; k < len; k++) begin
				draw_samples(style, e, i);
				send_neuron(e, i, 1'($urandom), k == len - 1);
			end
			sent += len;
		end
	endtask

	task automatic test_reset_defaults();
		gap_pct = 30;
		send_neuron(16'h1000, 16'h1000, 1'b0, 1'b1);
		send_neuron(16'h1000, 16'h0000, 1'b0, 1'b0);
		send_neuron(16'h0800, 16'h0400, 1'b1, 1'b1);
		settle();
	endtask

	task automatic test_extremes();
		send_neuron(16'h8000, 16'h7FFF, 1'b1, 1'b1);
		send_neuron(16'h7FFF, 16'h8000, 1'b0, 1'b1);
		send_neuron(16'h8000, 16'h8000, 1'b1, 1'b0);
		send_neuron(16'h7FFF, 16'hFFFF, 1'b1, 1'b1);
		send_neuron(16'h0000, 16'h8000, 1'b1, 1'b1);
		settle();
	endtask

	task automatic test_zero_error_minimum();
		write_reg(mert_pkg::REG_TIME_SCALE_MIN, 32'h0000_0000);
		send_neuron(16'h0000, 16'h0000, 1'b1, 1'b1);
		settle();
		write_reg(mert_pkg::REG_TIME_SCALE_MIN, 32'hFFFF_FFFF);
		send_neuron(16'h8000, 16'h8000, 1'b0, 1'b1);
		send_neuron(16'h1234, 16'h1234, 1'b1, 1'b0);
		send_neuron(16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
		settle();
	endtask

	task automatic test_masking();
		write_mask_enable(1'b1);
		// masked last neuron still closes the layer
		send_neuron(16'h4000, 16'h1000, 1'b1, 1'b0);
		send_neuron(16'h7FFF, 16'h8000, 1'b0, 1'b1);
		// fully masked layer falls back to the minimum
		send_neuron(16'h7FFF, 16'h0000, 1'b0, 1'b0);
		send_neuron(16'h0001, 16'h0002, 1'b0, 1'b1);
		settle();
		write_mask_enable(1'b0);
		send_neuron(16'h0100, 16'h0200, 1'b0, 1'b1);
		settle();
	endtask

	task automatic test_ratio_saturation();
		write_reg(mert_pkg::REG_TIME_SCALE_MIN, mert_pkg::TIME_SCALE_MIN_RST);
		for (int n = 4; n >= 2; n--) begin
			repeat (n)
				send_neuron(16'h8000, 16'h8000, 1'b1, 1'b0);
			send_neuron(16'h8000, 16'h8001, 1'b1, 1'b1);
		end
		settle();
	endtask

	task automatic test_random();
		gap_pct = 25;
		random_layers(325);
		settle();
		write_mask_enable(1'b1);
		write_reg(mert_pkg::REG_TIME_SCALE_MIN, $urandom);
		gap_pct = 50;
		random_layers(325);
		settle();
		write_mask_enable(1'($urandom));
		write_reg(mert_pkg::REG_TIME_SCALE_MIN, $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0);
		gap_pct = 10;
		random_layers(325);
		settle();
		write_mask_enable(1'($urandom));
		write_reg(mert_pkg::REG_TIME_SCALE_MIN, $urandom);
		gap_pct = 0;
		random_layers(325);
		settle();
	endtask

	initial begin
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_extremes();
		test_zero_error_minimum();
		test_masking();
		test_ratio_saturation();
		test_random();
		$display("%0d neurons sent, %0d layer results checked", neurons_in, layers_checked);
		$display("%0d layers fell back to the minimum, %0d saturated the ratio",
			minimum_layers, saturated_layers);
		if (failures == 0)
			$display("masked_error_ratio_timescale_top: match");
		else
			$display("masked_error_ratio_timescale_top: mismatch");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("masked_error_ratio_timescale_top: mismatch");
		$finish;
	end

endmodule
